// ----- rtl/tcpop_pkg.sv -----
// Shared types and constants of the TCP option parser.
package tcpop_pkg;

  // Largest option area that is walked; longer areas saturate to it
  localparam logic [5:0] MAX_OPT_BYTES = 6'd40;

  // Option kinds
  localparam logic [7:0] KIND_EOL       = 8'd0;
  localparam logic [7:0] KIND_NOP       = 8'd1;
  localparam logic [7:0] KIND_MSS       = 8'd2;
  localparam logic [7:0] KIND_WINDOW    = 8'd3;
  localparam logic [7:0] KIND_SACK_PERM = 8'd4;
  localparam logic [7:0] KIND_TIMESTAMP = 8'd8;

  // Exact option lengths, kind and length bytes included, and the minimum length
  localparam logic [7:0] LEN_MSS       = 8'd4;
  localparam logic [7:0] LEN_WINDOW    = 8'd3;
  localparam logic [7:0] LEN_SACK_PERM = 8'd2;
  localparam logic [7:0] LEN_TIMESTAMP = 8'd10;
  localparam logic [7:0] LEN_MIN       = 8'd2;

  // Presence flag bit positions
  localparam int unsigned FLAG_MSS    = 0;
  localparam int unsigned FLAG_WSCALE = 1;
  localparam int unsigned FLAG_TSTAMP = 2;
  localparam int unsigned FLAG_SACK   = 3;

  // Configuration register map (index taken from paddr[2])
  localparam logic       CFG_IDX_MAX_WSCALE = 1'b0;
  localparam logic [3:0] MAX_WSCALE_RESET   = 4'd14;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_KIND = 3'd1,
    PH_LEN  = 3'd2,
    PH_BODY = 3'd3,
    PH_DONE = 3'd4
  } phase_e;

  // One input item
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       first;
    logic       last;
    logic [5:0] area_len;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic        has_mss;
    logic        has_wscale;
    logic        has_tstamp;
    logic        has_sack_ok;
    logic [15:0] seg_size;
    logic [3:0]  wscale;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic        parse_error;
  } result_t;

endpackage

// ----- rtl/tcpop_if.sv -----
// Valid/ready channel interfaces for option bytes and parse results.
interface tcpop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic       first;
  logic       last;
  logic [5:0] area_len;

  modport source (output valid, output opt_byte, output first, output last,
                  output area_len, input ready);
  modport sink   (input valid, input opt_byte, input first, input last,
                  input area_len, output ready);
endinterface

interface tcpop_out_if;
  logic        valid;
  logic        ready;
  logic        has_mss;
  logic        has_wscale;
  logic        has_tstamp;
  logic        has_sack_ok;
  logic [15:0] seg_size;
  logic [3:0]  wscale;
  logic [31:0] ts_value;
  logic [31:0] ts_echo;
  logic        parse_error;

  modport source (output valid, output has_mss, output has_wscale, output has_tstamp,
                  output has_sack_ok, output seg_size, output wscale, output ts_value,
                  output ts_echo, output parse_error, input ready);
  modport sink   (input valid, input has_mss, input has_wscale, input has_tstamp,
                  input has_sack_ok, input seg_size, input wscale, input ts_value,
                  input ts_echo, input parse_error, output ready);
endinterface

// ----- rtl/tcp_option_parser.sv -----
// Top level of the TCP option parser: input register, walker, result register.
//
// Option bytes enter on in_i, one byte per item, in wire order. The item
// with first set samples area_len (saturated to 40), clears the presence
// and error flags and is itself parsed as the first option byte. The item
// with last set produces one result on out_o; other items produce none.
// Option values not seen in a packet keep what an earlier packet left.
//
// An accepted byte is held in the input register and parsed from there;
// for a last byte the result is then captured in the result register and
// shown on out_o. Throughput is one byte per cycle while no last byte waits
// on a stalled out_o, set by the walker state update between the registers.
// When out_o stalls, a last byte waits in the input register and in_i
// drops ready once that register is full; non-last bytes keep flowing.
// Reset clears the parse state, all held option values and both valid
// bits, and sets the window scale clamp to 14. The user must write the
// clamp over the APB-style port at address 0 only while no packet is in
// flight; the block itself does not enforce this.
module tcp_option_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcpop_in_if.sink    in_i,
  tcpop_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tcpop_pkg::*;

  logic       in_valid_q;
  in_item_t   in_item_q;
  logic       consume;
  logic       out_valid_q;
  result_t    out_q;
  result_t    res;
  logic [3:0] max_wscale;

  tcpop_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_wscale_o (max_wscale)
  );

  // A registered byte moves on unless it is a last byte and out_o is stalled
  assign consume    = in_valid_q && (!in_item_q.last || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || consume;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q.opt_byte <= in_i.opt_byte;
      in_item_q.first    <= in_i.first;
      in_item_q.last     <= in_i.last;
      in_item_q.area_len <= in_i.area_len;
    end
  end

  tcpop_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (consume),
    .item_i       (in_item_q),
    .max_wscale_i (max_wscale),
    .res_o        (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && in_item_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && in_item_q.last) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.has_mss     = out_q.has_mss;
  assign out_o.has_wscale  = out_q.has_wscale;
  assign out_o.has_tstamp  = out_q.has_tstamp;
  assign out_o.has_sack_ok = out_q.has_sack_ok;
  assign out_o.seg_size    = out_q.seg_size;
  assign out_o.wscale      = out_q.wscale;
  assign out_o.ts_value    = out_q.ts_value;
  assign out_o.ts_echo     = out_q.ts_echo;
  assign out_o.parse_error = out_q.parse_error;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(consume && in_item_q.last && out_valid_q && !out_o.ready))
    else $error("result overwritten while still pending");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_item_q.last |=> out_valid_q)
    else $error("last byte parsed without a result");

  a_hold_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !consume |=> in_valid_q && $stable(in_item_q))
    else $error("waiting byte lost from input register");

endmodule

// ----- rtl/tcpop_cfg.sv -----
// APB-style configuration register: window scale clamp.
module tcpop_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  max_wscale_o
);
  import tcpop_pkg::*;

  logic [3:0] max_wscale_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == CFG_IDX_MAX_WSCALE);

  // Register write on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wscale_q <= MAX_WSCALE_RESET;
    end else if (wr_en) begin
      max_wscale_q <= pwdata[3:0];
    end
  end

  // Read-back; unmapped address reads zero
  always_comb begin
    unique case (paddr[2])
      CFG_IDX_MAX_WSCALE: prdata = {28'd0, max_wscale_q};
      default:            prdata = 32'd0;
    endcase
  end

  assign max_wscale_o = max_wscale_q;

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> max_wscale_q == $past(pwdata[3:0]))
    else $error("clamp register did not take written value");

endmodule

// ----- rtl/tcpop_parse.sv -----
// Per-byte option walker: parse state, option commit and result assembly.
module tcpop_parse (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  tcpop_pkg::in_item_t item_i,
  input  logic [3:0]          max_wscale_i,
  output tcpop_pkg::result_t  res_o
);
  import tcpop_pkg::*;

  phase_e      phase_q, phase_d;
  logic [5:0]  left_q, left_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  len_q, len_d;
  logic [5:0]  bidx_q, bidx_d;
  logic [63:0] accum_q, accum_d;
  logic [3:0]  flags_q, flags_d;
  logic [15:0] mss_q, mss_d;
  logic [3:0]  wscale_q, wscale_d;
  logic [31:0] tsval_q, tsval_d;
  logic [31:0] tsecr_q, tsecr_d;
  logic        err_q, err_d;
  logic        do_commit;
  logic [5:0]  alen;
  logic [7:0]  b;

  assign b = item_i.opt_byte;

  // Next state: packet start, one walk step, option commit, then idle after a last byte
  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    kind_d    = kind_q;
    len_d     = len_q;
    bidx_d    = bidx_q;
    accum_d   = accum_q;
    flags_d   = flags_q;
    mss_d     = mss_q;
    wscale_d  = wscale_q;
    tsval_d   = tsval_q;
    tsecr_d   = tsecr_q;
    err_d     = err_q;
    do_commit = 1'b0;
    alen      = (item_i.area_len > MAX_OPT_BYTES) ? MAX_OPT_BYTES : item_i.area_len;

    if (step_i && item_i.first) begin
      left_d  = alen;
      flags_d = '0;
      err_d   = 1'b0;
      kind_d  = '0;
      len_d   = '0;
      bidx_d  = '0;
      accum_d = '0;
      phase_d = (alen == 6'd0) ? PH_DONE : PH_KIND;
    end

    if (step_i && left_d != 6'd0 &&
        (phase_d == PH_KIND || phase_d == PH_LEN || phase_d == PH_BODY)) begin
      unique case (phase_d)
        PH_KIND: begin
          kind_d = b;
          if (b == KIND_EOL) begin
            phase_d = PH_DONE;
          end else if (b == KIND_NOP) begin
            left_d  = left_d - 6'd1;
            phase_d = (left_d == 6'd0) ? PH_DONE : PH_KIND;
          end else if (left_d < 6'd2) begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
          end else begin
            left_d  = left_d - 6'd1;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          len_d = b;
          if (b < LEN_MIN || b > ({2'b00, left_d} + 8'd1)) begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
          end else begin
            left_d  = left_d - 6'd1;
            accum_d = '0;
            bidx_d  = '0;
            if (b == LEN_MIN) begin
              do_commit = 1'b1;
              phase_d   = (left_d == 6'd0) ? PH_DONE : PH_KIND;
            end else begin
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          accum_d = {accum_d[55:0], b};
          bidx_d  = bidx_d + 6'd1;
          left_d  = left_d - 6'd1;
          if (({2'b00, bidx_d} + 8'd2) >= len_d) begin
            do_commit = 1'b1;
            phase_d   = (left_d == 6'd0) ? PH_DONE : PH_KIND;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    // Take the finished option when its length is exact
    if (do_commit) begin
      if (kind_d == KIND_MSS && len_d == LEN_MSS) begin
        mss_d             = accum_d[15:0];
        flags_d[FLAG_MSS] = 1'b1;
      end else if (kind_d == KIND_WINDOW && len_d == LEN_WINDOW) begin
        wscale_d = (accum_d[7:0] > {4'd0, max_wscale_i}) ? max_wscale_i : accum_d[3:0];
        flags_d[FLAG_WSCALE] = 1'b1;
      end else if (kind_d == KIND_TIMESTAMP && len_d == LEN_TIMESTAMP) begin
        tsval_d              = accum_d[63:32];
        tsecr_d              = accum_d[31:0];
        flags_d[FLAG_TSTAMP] = 1'b1;
      end else if (kind_d == KIND_SACK_PERM && len_d == LEN_SACK_PERM) begin
        flags_d[FLAG_SACK] = 1'b1;
      end
    end

    if (step_i && item_i.last) begin
      phase_d = PH_IDLE;
    end
  end

  // Result as seen after this byte
  always_comb begin
    res_o.has_mss     = flags_d[FLAG_MSS];
    res_o.has_wscale  = flags_d[FLAG_WSCALE];
    res_o.has_tstamp  = flags_d[FLAG_TSTAMP];
    res_o.has_sack_ok = flags_d[FLAG_SACK];
    res_o.seg_size    = mss_d;
    res_o.wscale      = wscale_d;
    res_o.ts_value    = tsval_d;
    res_o.ts_echo     = tsecr_d;
    res_o.parse_error = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      left_q   <= '0;
      kind_q   <= '0;
      len_q    <= '0;
      bidx_q   <= '0;
      accum_q  <= '0;
      flags_q  <= '0;
      mss_q    <= '0;
      wscale_q <= '0;
      tsval_q  <= '0;
      tsecr_q  <= '0;
      err_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      kind_q   <= kind_d;
      len_q    <= len_d;
      bidx_q   <= bidx_d;
      accum_q  <= accum_d;
      flags_q  <= flags_d;
      mss_q    <= mss_d;
      wscale_q <= wscale_d;
      tsval_q  <= tsval_d;
      tsecr_q  <= tsecr_d;
      err_q    <= err_d;
    end
  end

  a_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    left_q <= MAX_OPT_BYTES)
    else $error("bytes left exceeds option area maximum");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.last |=> phase_q == PH_IDLE)
    else $error("parser not idle after last byte");

endmodule
